[hdl/omni_fk_pkg.sv]
// ----------------------------------------------------------------------------
// omni_fk_pkg
// shared types, constants and elaboration-time cordic tables for the
// omni wheel forward kinematics block
// ----------------------------------------------------------------------------
package omni_fk_pkg;

    // cordic datapath sizing
    localparam int CORDIC_STAGES = 48;
    localparam int XY_FRAC       = 50;
    localparam int XY_W          = 53;
    localparam int Z_FRAC        = 40;
    localparam int Z_W           = 55;

    // angle constants in centidegrees
    localparam logic [17:0] FULL_TURN    = 18'd36000;
    localparam logic [17:0] QUARTER_TURN = 18'd9000;
    localparam logic [17:0] EIGHTH_TURN  = 18'd4500;
    localparam logic [18:0] TURN_BIAS    = 19'd108000;

    localparam real PI_R = 3.14159265358979323846;
    // centidegrees per radian
    localparam real CD_PER_RAD = 18000.0 / PI_R;

    typedef logic signed [XY_W-1:0] t_xy;
    typedef logic signed [Z_W-1:0]  t_z;

    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } t_quad;

    // item data that rides along the cordic row
    typedef struct packed {
        t_quad              quad;
        logic               swap;
        logic signed [15:0] va;
        logic signed [15:0] vb;
        logic signed [15:0] vc;
    } t_side;

    // atan(2^-idx) in centidegrees with Z_FRAC fraction bits
    function automatic longint cordic_atan(input int idx);
        real a;
        a = $atan(2.0 ** (-idx)) * CD_PER_RAD * (2.0 ** Z_FRAC);
        return longint'(a);
    endfunction

    // inverse cordic gain with XY_FRAC fraction bits
    function automatic longint cordic_gain();
        real g;
        g = 1.0;
        for (int i = 0; i < CORDIC_STAGES; i++) begin
            g = g * $pow(1.0 + 2.0 ** (-2 * i), -0.5);
        end
        return longint'(g * (2.0 ** XY_FRAC));
    endfunction

endpackage

[hdl/omni_fk_cordic_cell.sv]
// ----------------------------------------------------------------------------
// omni_fk_cordic_cell
// one rotation-mode cordic micro-rotation with registered outputs
// ----------------------------------------------------------------------------
module omni_fk_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  omni_fk_pkg::t_xy    i_x,
    input  omni_fk_pkg::t_xy    i_y,
    input  omni_fk_pkg::t_z     i_z,
    input  omni_fk_pkg::t_side  i_side,
    output logic                o_valid,
    output omni_fk_pkg::t_xy    o_x,
    output omni_fk_pkg::t_xy    o_y,
    output omni_fk_pkg::t_z     o_z,
    output omni_fk_pkg::t_side  o_side
);

    localparam omni_fk_pkg::t_z ATAN_V =
        omni_fk_pkg::t_z'(omni_fk_pkg::cordic_atan(STAGE));

    logic               r_valid;
    omni_fk_pkg::t_xy   r_x, r_y, n_x, n_y;
    omni_fk_pkg::t_z    r_z, n_z;
    omni_fk_pkg::t_side r_side;
    omni_fk_pkg::t_xy   x_sh, y_sh;

    always_comb begin
        x_sh = i_x >>> STAGE;
        y_sh = i_y >>> STAGE;
        if (i_z[omni_fk_pkg::Z_W-1]) begin
            n_x = i_x + y_sh;
            n_y = i_y - x_sh;
            n_z = i_z + ATAN_V;
        end else begin
            n_x = i_x - y_sh;
            n_y = i_y + x_sh;
            n_z = i_z - ATAN_V;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_z    <= n_z;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;
    assign o_side  = r_side;

endmodule

[hdl/omni_fk_mix.sv]
// ----------------------------------------------------------------------------
// omni_fk_mix
// rounds sine/cosine, builds the rotated matrix and applies it to the speeds
// ----------------------------------------------------------------------------
module omni_fk_mix #(
    parameter int TRIG_FRACTION_BITS = 15
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  omni_fk_pkg::t_xy    i_x,
    input  omni_fk_pkg::t_xy    i_y,
    input  omni_fk_pkg::t_side  i_side,
    output logic                o_valid,
    output logic signed [17:0]  o_velocity_x,
    output logic signed [17:0]  o_velocity_y
);

    localparam int F   = TRIG_FRACTION_BITS;
    localparam int TW  = F + 2;
    localparam int HW  = F + 1;
    localparam int PW  = 2 * F + 3;
    localparam int KW  = F + 3;
    localparam int MW  = KW + 16;
    localparam int SW  = MW + 2;
    localparam int SHR = omni_fk_pkg::XY_FRAC - F;
    localparam longint H_L = longint'($floor($sqrt(3.0) / 2.0 * (2.0 ** F) + 0.5));
    localparam logic signed [HW-1:0] H = signed'(HW'(H_L));
    localparam omni_fk_pkg::t_xy TRIG_HALF = omni_fk_pkg::t_xy'(1) <<< (SHR - 1);
    localparam logic signed [PW:0] K_HALF = (PW + 1)'(1) <<< (F - 1);
    localparam logic signed [SW-1:0] V_HALF = SW'(1) <<< (F - 1);

    logic [4:0] r_valid;

    // stage 1: rounded and unfolded sine, cosine
    logic signed [TW-1:0] r_s, r_c, n_s, n_c;
    logic signed [TW-1:0] s1, c1, so, co;
    omni_fk_pkg::t_xy     x_rnd, y_rnd;
    omni_fk_pkg::t_side   r_side1, r_side2, r_side3;

    // stage 2: products with sqrt3/2
    logic signed [PW-1:0] r_sh, r_ch;
    logic signed [TW-1:0] r_s2, r_c2;

    // stage 3: matrix coefficients
    logic signed [KW-1:0] r_kx0, r_k1x, r_k2x, r_ky0, r_k1y, r_k2y;
    logic signed [PW:0]   z1x, z2x, z1y, z2y, c_up, s_up;
    logic signed [PW:0]   q1x, q2x, q1y, q2y;

    // stage 4: coefficient times speed
    logic signed [MW-1:0] r_px0, r_px1, r_px2, r_py0, r_py1, r_py2;

    // stage 5: output register
    logic signed [SW-1:0] sum_x, sum_y;
    logic signed [17:0]   r_vx, r_vy;

    always_comb begin
        x_rnd = i_x + TRIG_HALF;
        y_rnd = i_y + TRIG_HALF;
        so    = TW'(y_rnd >>> SHR);
        co    = TW'(x_rnd >>> SHR);
        s1    = i_side.swap ? co : so;
        c1    = i_side.swap ? so : co;
        case (i_side.quad)
            omni_fk_pkg::QUAD_0: begin n_s = s1;  n_c = c1;  end
            omni_fk_pkg::QUAD_1: begin n_s = c1;  n_c = -s1; end
            omni_fk_pkg::QUAD_2: begin n_s = -s1; n_c = -c1; end
            default:             begin n_s = -c1; n_c = s1;  end
        endcase
    end

    always_comb begin
        c_up = (PW + 1)'(r_c2) <<< (F - 1);
        s_up = (PW + 1)'(r_s2) <<< (F - 1);
        z1x  = c_up + (PW + 1)'(r_sh);
        z2x  = c_up - (PW + 1)'(r_sh);
        z1y  = (PW + 1)'(r_ch) - s_up;
        z2y  = -s_up - (PW + 1)'(r_ch);
        q1x  = (z1x + K_HALF) >>> F;
        q2x  = (z2x + K_HALF) >>> F;
        q1y  = (z1y + K_HALF) >>> F;
        q2y  = (z2y + K_HALF) >>> F;
        sum_x = SW'(r_px0) + SW'(r_px1) + SW'(r_px2) + V_HALF;
        sum_y = SW'(r_py0) + SW'(r_py1) + SW'(r_py2) + V_HALF;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[3:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s     <= n_s;
            r_c     <= n_c;
            r_side1 <= i_side;

            r_sh    <= PW'(r_s) * PW'(H);
            r_ch    <= PW'(r_c) * PW'(H);
            r_s2    <= r_s;
            r_c2    <= r_c;
            r_side2 <= r_side1;

            r_kx0   <= -KW'(r_c2);
            r_ky0   <= KW'(r_s2);
            r_k1x   <= KW'(q1x);
            r_k2x   <= KW'(q2x);
            r_k1y   <= KW'(q1y);
            r_k2y   <= KW'(q2y);
            r_side3 <= r_side2;

            r_px0   <= MW'(r_kx0) * MW'(r_side3.va);
            r_px1   <= MW'(r_k1x) * MW'(r_side3.vb);
            r_px2   <= MW'(r_k2x) * MW'(r_side3.vc);
            r_py0   <= MW'(r_ky0) * MW'(r_side3.va);
            r_py1   <= MW'(r_k1y) * MW'(r_side3.vb);
            r_py2   <= MW'(r_k2y) * MW'(r_side3.vc);

            r_vx    <= 18'(sum_x >>> F);
            r_vy    <= 18'(sum_y >>> F);
        end
    end

    assign o_valid      = r_valid[4];
    assign o_velocity_x = r_vx;
    assign o_velocity_y = r_vy;

endmodule

[hdl/omni_wheel_velocity_to_field_frame_core.sv]
// ----------------------------------------------------------------------------
// omni_wheel_velocity_to_field_frame_core
// three-wheel omni base: wheel speeds and heading to field-frame velocity
// ----------------------------------------------------------------------------
// pipeline: 2 angle stages, 48 cordic cells and 5 matrix stages between the
//   input transfer and the result valid
// throughput: one transfer per cycle; the whole pipe holds only while a
//   finished result waits under i_stall
// reset: synchronous active low, clears all valid bits and the reference
//   heading; payload registers are not reset
module omni_wheel_velocity_to_field_frame_core #(
    parameter int TRIG_FRACTION_BITS = 15
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration
    input  logic               i_cfg_we,
    input  logic signed [16:0] i_cfg_data,
    // input channel
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [15:0] i_heading,
    input  logic signed [15:0] i_wheel_speed_a,
    input  logic signed [15:0] i_wheel_speed_b,
    input  logic signed [15:0] i_wheel_speed_c,
    // output channel
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [17:0] o_velocity_x,
    output logic signed [17:0] o_velocity_y
);

    localparam int N = omni_fk_pkg::CORDIC_STAGES;
    localparam omni_fk_pkg::t_xy X_INIT =
        omni_fk_pkg::t_xy'(omni_fk_pkg::cordic_gain());

    // reference heading register
    logic signed [16:0] r_ref;

    // global advance: the pipe moves unless a result is held at the output
    logic en;
    logic mix_valid;

    // stage a: theta reduced modulo one turn
    logic               r_a_valid;
    logic [15:0]        r_a_t, n_a_t;
    logic signed [17:0] diff;
    logic [17:0]        biased;
    logic [15:0]        va_a, vb_a, vc_a;
    logic signed [15:0] r_a_va, r_a_vb, r_a_vc;

    // stage b: quadrant, octant fold, cordic start angle
    logic               r_b_valid;
    omni_fk_pkg::t_z    r_b_z;
    omni_fk_pkg::t_side r_b_side, n_b_side;
    logic [17:0]        t_ext, rem, cd;
    omni_fk_pkg::t_quad quad;
    logic [17:0]        quad_base;

    // cordic row
    logic               ch_valid [0:N];
    omni_fk_pkg::t_xy   ch_x     [0:N];
    omni_fk_pkg::t_xy   ch_y     [0:N];
    omni_fk_pkg::t_z    ch_z     [0:N];
    omni_fk_pkg::t_side ch_side  [0:N];

    assign en      = !(mix_valid && i_stall);
    assign o_stall = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref <= '0;
        end else if (i_cfg_we) begin
            r_ref <= i_cfg_data;
        end
    end

    // theta plus three turns is always positive and below six turns
    always_comb begin
        diff   = 18'(i_heading) - 18'(r_ref);
        biased = 18'(19'(diff) + omni_fk_pkg::TURN_BIAS);
        if (biased >= 18'd180000) begin
            n_a_t = 16'(biased - 18'd180000);
        end else if (biased >= 18'd144000) begin
            n_a_t = 16'(biased - 18'd144000);
        end else if (biased >= 18'd108000) begin
            n_a_t = 16'(biased - 18'd108000);
        end else if (biased >= 18'd72000) begin
            n_a_t = 16'(biased - 18'd72000);
        end else if (biased >= omni_fk_pkg::FULL_TURN) begin
            n_a_t = 16'(biased - omni_fk_pkg::FULL_TURN);
        end else begin
            n_a_t = 16'(biased);
        end
        va_a = i_wheel_speed_a;
        vb_a = i_wheel_speed_b;
        vc_a = i_wheel_speed_c;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else if (en) begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
        end
    end

    // fold into the first octant; past 45 degrees sine and cosine swap
    always_comb begin
        t_ext = 18'(r_a_t);
        if (t_ext >= 18'd27000) begin
            quad      = omni_fk_pkg::QUAD_3;
            quad_base = 18'd27000;
        end else if (t_ext >= 18'd18000) begin
            quad      = omni_fk_pkg::QUAD_2;
            quad_base = 18'd18000;
        end else if (t_ext >= omni_fk_pkg::QUARTER_TURN) begin
            quad      = omni_fk_pkg::QUAD_1;
            quad_base = omni_fk_pkg::QUARTER_TURN;
        end else begin
            quad      = omni_fk_pkg::QUAD_0;
            quad_base = '0;
        end
        rem = t_ext - quad_base;
        n_b_side.quad = quad;
        n_b_side.swap = (rem > omni_fk_pkg::EIGHTH_TURN);
        n_b_side.va   = r_a_va;
        n_b_side.vb   = r_a_vb;
        n_b_side.vc   = r_a_vc;
        cd = n_b_side.swap ? (omni_fk_pkg::QUARTER_TURN - rem) : rem;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_t    <= n_a_t;
            r_a_va   <= signed'(va_a);
            r_a_vb   <= signed'(vb_a);
            r_a_vc   <= signed'(vc_a);
            r_b_z    <= omni_fk_pkg::t_z'(cd) <<< omni_fk_pkg::Z_FRAC;
            r_b_side <= n_b_side;
        end
    end

    // cordic start vector: gain-compensated unit on the x axis
    assign ch_valid[0] = r_b_valid;
    assign ch_x[0]     = X_INIT;
    assign ch_y[0]     = '0;
    assign ch_z[0]     = r_b_z;
    assign ch_side[0]  = r_b_side;

    for (genvar g = 0; g < N; g++) begin : g_cell
        omni_fk_cordic_cell #(
            .STAGE (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (ch_valid[g]),
            .i_x     (ch_x[g]),
            .i_y     (ch_y[g]),
            .i_z     (ch_z[g]),
            .i_side  (ch_side[g]),
            .o_valid (ch_valid[g+1]),
            .o_x     (ch_x[g+1]),
            .o_y     (ch_y[g+1]),
            .o_z     (ch_z[g+1]),
            .o_side  (ch_side[g+1])
        );
    end

    // residual angle after the last cell is not needed
    omni_fk_mix #(
        .TRIG_FRACTION_BITS (TRIG_FRACTION_BITS)
    ) u_mix (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (en),
        .i_valid      (ch_valid[N] && (ch_z[N] == ch_z[N])),
        .i_x          (ch_x[N]),
        .i_y          (ch_y[N]),
        .i_side       (ch_side[N]),
        .o_valid      (mix_valid),
        .o_velocity_x (o_velocity_x),
        .o_velocity_y (o_velocity_y)
    );

    assign o_valid = mix_valid;

endmodule

[hdl/omni_fk_chk.sv]
// ----------------------------------------------------------------------------
// omni_fk_chk
// port-level checks for the omni wheel kinematics core, bound to the top
// ----------------------------------------------------------------------------
module omni_fk_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_stall,
    input logic               o_valid,
    input logic               i_stall,
    input logic signed [17:0] o_velocity_x,
    input logic signed [17:0] o_velocity_y
);

    // a held result keeps its values
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_velocity_x) && $stable(o_velocity_y))
        else $error("held result changed");

    // the input side stalls exactly when a result is held
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall == (o_valid && i_stall))
        else $error("input stall does not follow output back-pressure");

    // no result right after reset
    a_reset: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !o_valid)
        else $error("result valid after reset");

    // rotated wheel sums stay inside three full-scale speeds
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_velocity_x >= -18'sd98304 && o_velocity_x <= 18'sd98304
                 && o_velocity_y >= -18'sd98304 && o_velocity_y <= 18'sd98304)
        else $error("velocity out of range");

endmodule

bind omni_wheel_velocity_to_field_frame_core omni_fk_chk u_omni_fk_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_velocity_x (o_velocity_x),
    .o_velocity_y (o_velocity_y)
);

[tb/sv/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the omni wheel forward kinematics core: drives
// heading and wheel speed transfers with random gaps and receiver stalls,
// predicts the field-frame velocities bit for bit and compares in order
// ----------------------------------------------------------------------------

// velocity predictor and in-order store of expected velocities
class velocity_scoreboard;
    typedef struct {
        logic signed [17:0] vx;
        logic signed [17:0] vy;
    } t_velocity;

    localparam int F = 15;
    localparam longint unsigned PI_Q62 = 64'hC90FDAA22168C235;
    localparam longint unsigned HALF_SQRT3_Q62 = 64'h376CF5D0B09954E7;
    localparam longint unsigned ONE_Q62 = 64'h4000000000000000;

    t_velocity pending[$];
    longint    ref_heading;
    int        errors;
    int        checked;

    function new();
        ref_heading = 0;
        errors = 0;
        checked = 0;
    endfunction

    function void set_reference(logic signed [16:0] value);
        ref_heading = value;
    endfunction

    task report(string what, logic signed [17:0] got, logic signed [17:0] want);
        $display("error: %s got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    static function longint unsigned mul_q62(longint unsigned a, longint unsigned b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    static function longint unsigned round_q62(longint unsigned v);
        return (v + (64'd1 << (61 - F))) >> (62 - F);
    endfunction

    static function longint round_f(longint z);
        return (z + (64'sd1 <<< (F - 1))) >>> F;
    endfunction

    // series sine and cosine in q62 over the first octant
    static function void octant(longint unsigned cd, output longint unsigned s,
                                output longint unsigned c);
        longint unsigned q, r, x, x2, ts, tc;
        q = PI_Q62 / 18000;
        r = PI_Q62 % 18000;
        x = cd * q + (cd * r) / 18000;
        x2 = mul_q62(x, x);
        ts = x; tc = ONE_Q62; s = x; c = ONE_Q62;
        for (int k = 1; k <= 12; k++) begin
            ts = mul_q62(ts, x2) / longint'((2 * k) * (2 * k + 1));
            tc = mul_q62(tc, x2) / longint'((2 * k - 1) * (2 * k));
            if (k % 2 == 1) begin
                s -= ts; c -= tc;
            end else begin
                s += ts; c += tc;
            end
        end
    endfunction

    function void note_input(logic signed [15:0] heading, logic signed [15:0] va,
                             logic signed [15:0] vb, logic signed [15:0] vc);
        longint d, t, quad, r, s1, c1, s, c, h, k1x, k2x, k1y, k2y, half;
        longint unsigned so, co;
        t_velocity e;
        d = longint'(heading) - ref_heading;
        t = (d + 108000) % 36000;
        quad = t / 9000;
        r = t % 9000;
        if (r <= 4500) begin
            octant(r, so, co);
            s1 = round_q62(so); c1 = round_q62(co);
        end else begin
            octant(9000 - r, so, co);
            s1 = round_q62(co); c1 = round_q62(so);
        end
        case (quad)
            0: begin s = s1;  c = c1;  end
            1: begin s = c1;  c = -s1; end
            2: begin s = -s1; c = -c1; end
            default: begin s = -c1; c = s1; end
        endcase
        half = 64'sd1 <<< (F - 1);
        h = round_q62(HALF_SQRT3_Q62);
        k1x = round_f(c * half + s * h);
        k2x = round_f(c * half - s * h);
        k1y = round_f(-s * half + c * h);
        k2y = round_f(-s * half - c * h);
        e.vx = 18'(round_f(-c * va + k1x * vb + k2x * vc));
        e.vy = 18'(round_f(s * va + k1y * vb + k2y * vc));
        pending.push_back(e);
    endfunction

    task check_result(logic signed [17:0] vx, logic signed [17:0] vy);
        t_velocity e;
        if (pending.size() == 0) begin
            $display("error: velocity transfer with nothing pending at %0t", $realtime);
            errors++;
        end else begin
            e = pending.pop_front();
            checked++;
            if (vx !== e.vx) report("velocity_x", vx, e.vx);
            if (vy !== e.vy) report("velocity_y", vy, e.vy);
        end
    endtask
endclass

module tb;
    localparam int LATENCY = 55;
    localparam int LIMIT   = 200000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic signed [16:0] i_cfg_data = '0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic signed [15:0] i_heading = '0;
    logic signed [15:0] i_wheel_speed_a = '0;
    logic signed [15:0] i_wheel_speed_b = '0;
    logic signed [15:0] i_wheel_speed_c = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [17:0] o_velocity_x;
    logic signed [17:0] o_velocity_y;

    velocity_scoreboard sb = new();

    // idling switches shared by sender and receiver
    bit  gaps_on = 1'b0;
    bit  hold_req = 1'b0;
    bit  hold_done = 1'b0;
    int  sent = 0;
    longint cycles = 0;

    always #4 i_clk = ~i_clk;

    omni_wheel_velocity_to_field_frame_core #(
        .TRIG_FRACTION_BITS(15)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_heading      (i_heading),
        .i_wheel_speed_a(i_wheel_speed_a),
        .i_wheel_speed_b(i_wheel_speed_b),
        .i_wheel_speed_c(i_wheel_speed_c),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_velocity_x   (o_velocity_x),
        .o_velocity_y   (o_velocity_y)
    );

    // timeout watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("omni_wheel_velocity_to_field_frame_core: mismatch");
            $finish;
        end
    end

    // result monitor: a transfer is valid high with stall low at the edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) sb.check_result(o_velocity_x, o_velocity_y);
    end

    // receiver: random stalls, plus one long hold-off that backs up the pipe
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                i_stall <= 1'b1;
                repeat (299) @(posedge i_clk);
                hold_done = 1'b1;
            end else begin
                i_stall <= gaps_on ? ($urandom_range(99) < 17) : 1'b0;
            end
        end
    end

    // one input transfer, with an optional random gap ahead of it
    task send_sample(logic signed [15:0] heading, logic signed [15:0] va,
                     logic signed [15:0] vb, logic signed [15:0] vc);
        while (gaps_on && $urandom_range(99) < 17) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_heading <= heading;
        i_wheel_speed_a <= va;
        i_wheel_speed_b <= vb;
        i_wheel_speed_c <= vc;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_input(heading, va, vb, vc);
        sent++;
    endtask

    // reference heading write, only with the pipe drained
    task write_reference(logic signed [16:0] value);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_reference(value);
    endtask

    function automatic logic signed [15:0] rand_speed();
        case ($urandom_range(5))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'($urandom_range(20)) - 16'sd10;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic signed [15:0] rand_heading();
        case ($urandom_range(9))
            // quadrant and octant borders
            0: return 16'(int'($urandom_range(8)) * 4500 - 18000);
            // raw bit pattern, often outside the nominal range
            1: return 16'($urandom);
            default: return 16'(int'($urandom_range(36000)) - 18000);
        endcase
    endfunction

    task random_block(int count);
        for (int n = 0; n < count; n++) begin
            // quiet stretch without any idling on either side
            gaps_on = !(n >= 40 && n < 110);
            if (n == 130) hold_req = 1'b1;
            send_sample(rand_heading(), rand_speed(), rand_speed(), rand_speed());
        end
        gaps_on = 1'b1;
    endtask

    initial begin
        logic signed [15:0] hd [0:11];
        hd = '{-16'sd18000, 16'sd18000, 16'sd0, 16'sd4500, 16'sd9000, -16'sd9000,
               16'sd13500, -16'sd4500, 16'sd4499, 16'sd4501, 16'sh7fff, 16'sh8000};
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: turn borders, octant ties, speed extremes
        for (int j = 0; j < 12; j++) begin
            send_sample(hd[j], 16'sh7fff, 16'sh7fff, 16'sh7fff);
            send_sample(hd[j], 16'sh8000, 16'sh7fff, 16'sh8000);
        end
        send_sample(16'sd1234, 16'sd0, 16'sd0, 16'sd0);

        // reference heading sweep: reset, extremes, out of range, random
        gaps_on = 1'b1;
        random_block(200);
        write_reference(17'sd36000);
        random_block(120);
        write_reference(-17'sd36000);
        random_block(120);
        write_reference(17'sh0ffff);
        random_block(60);
        write_reference(17'sh10000);
        random_block(60);
        write_reference(17'(int'($urandom_range(72000)) - 36000));
        random_block(150);

        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 20) @(posedge i_clk);

        $display("run covered %0d input transfers, %0d velocity checks, six reference headings",
                 sent, sb.checked);
        if (sb.errors == 0) begin
            $display("omni_wheel_velocity_to_field_frame_core: match");
        end else begin
            $display("omni_wheel_velocity_to_field_frame_core: mismatch");
        end
        $finish;
    end
endmodule
